/* sv/tqle_pkg.sv */
package tqle_pkg;

  // Default table geometry.
  localparam int DEF_PITCH_BUCKETS   = 8;
  localparam int DEF_FORMANT_BUCKETS = 8;
  localparam int DEF_ACTIONS         = 5;

  // Field widths fixed by the interface.
  localparam int BUCKET_W = 3;
  localparam int ACT_W    = 3;
  localparam int DRAW_W   = 16;
  localparam int RATE_W   = 17;
  localparam int Q_W      = 32;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W = 2;

  // One in Q1.16.
  localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 2'd2;

  localparam logic [RATE_W-1:0] EPSILON_RESET    = 17'd6554;
  localparam logic [RATE_W-1:0] LEARN_RATE_RESET = 17'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RESET   = 17'd58982;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_MUL_G,
    ST_TARGET,
    ST_MUL_A,
    ST_NEWQ,
    ST_EMIT
  } tqle_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic scan_rd;
    logic mul_g;
    logic target;
    logic mul_a;
    logic newq;
    logic emit;
  } tqle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic start_explore;
    logic scan_last;
    logic upd;
  } tqle_status_t;

endpackage

/* sv/tabular_q_learning_engine.sv */
// Tabular Q-learning engine. Issue an item by raising start while busy is
// low; op 0 picks an action for a (pitch, formant) state, op 1 applies one
// Q-learning update and bumps the visit count. Each item returns exactly one
// result beat, shown for a single cycle with out_valid high; the receiver
// cannot hold it off, so it must take the beat in that cycle. After reset
// the block clears both tables, one entry a cycle, with busy high. Busy
// then stays high from an accepted item until its result, so a new item is
// only taken once the last is done. An exploring pick goes straight to its
// result; a greedy pick first scans its row, and an update scans the row of
// the next state and then runs the two dependent multiplies of the update,
// each in its own state. The single read port of the tables walks the row
// one action a cycle.
module tabular_q_learning_engine #(
  parameter int PITCH_BUCKETS   = tqle_pkg::DEF_PITCH_BUCKETS,
  parameter int FORMANT_BUCKETS = tqle_pkg::DEF_FORMANT_BUCKETS,
  parameter int ACTIONS         = tqle_pkg::DEF_ACTIONS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [tqle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tqle_pkg::RATE_W-1:0]         cfg_wdata,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_pitch_bucket,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_formant_bucket,
  input  logic [tqle_pkg::ACT_W-1:0]          in_taken_action,
  input  logic signed [tqle_pkg::Q_W-1:0]     in_reward,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_next_pitch_bucket,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_next_formant_bucket,
  input  logic [tqle_pkg::DRAW_W-1:0]         in_explore_draw,
  input  logic [tqle_pkg::ACT_W-1:0]          in_explore_action,
  // Result channel.
  output logic                                out_valid,
  output logic [tqle_pkg::ACT_W-1:0]          out_chosen_action,
  output logic                                out_explored,
  output logic signed [tqle_pkg::Q_W-1:0]     out_q_value,
  output logic [tqle_pkg::CNT_W-1:0]          out_visit_count
);

  // Rate registers in Q1.16. Values above one are clamped to one where they
  // are used; epsilon is compared as written, so 65536 or more always explores.
  logic [tqle_pkg::RATE_W-1:0] epsilon_r;
  logic [tqle_pkg::RATE_W-1:0] learn_rate_r;
  logic [tqle_pkg::RATE_W-1:0] discount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epsilon_r    <= tqle_pkg::EPSILON_RESET;
      learn_rate_r <= tqle_pkg::LEARN_RATE_RESET;
      discount_r   <= tqle_pkg::DISCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tqle_pkg::REG_EPSILON:    epsilon_r    <= cfg_wdata;
        tqle_pkg::REG_LEARN_RATE: learn_rate_r <= cfg_wdata;
        tqle_pkg::REG_DISCOUNT:   discount_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tqle_pkg::tqle_cmd_t    cmd;
  tqle_pkg::tqle_status_t st;

  // The controller sequences the clearing pass, the row scan and the
  // update steps; the datapath holds the tables and all arithmetic.
  tqle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  tqle_datapath #(
    .PITCH_BUCKETS   (PITCH_BUCKETS),
    .FORMANT_BUCKETS (FORMANT_BUCKETS),
    .ACTIONS         (ACTIONS)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .epsilon                (epsilon_r),
    .learn_rate             (learn_rate_r),
    .discount               (discount_r),
    .in_op                  (in_op),
    .in_pitch_bucket        (in_pitch_bucket),
    .in_formant_bucket      (in_formant_bucket),
    .in_taken_action        (in_taken_action),
    .in_reward              (in_reward),
    .in_next_pitch_bucket   (in_next_pitch_bucket),
    .in_next_formant_bucket (in_next_formant_bucket),
    .in_explore_draw        (in_explore_draw),
    .in_explore_action      (in_explore_action),
    .out_valid              (out_valid),
    .out_chosen_action      (out_chosen_action),
    .out_explored           (out_explored),
    .out_q_value            (out_q_value),
    .out_visit_count        (out_visit_count)
  );

  // A result beat is only ever shown while the block is ready for the next item.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat shown while busy");

  // Result beats never come back to back.
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat longer than one cycle");

  // An exploring pick carries neither a value nor a count.
  a_explore_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_explored) |-> (out_q_value == 32'sd0 && out_visit_count == 32'd0))
    else $error("explored pick with nonzero value or count");

endmodule

/* sv/tqle_datapath.sv */
module tqle_datapath #(
  parameter int PITCH_BUCKETS   = tqle_pkg::DEF_PITCH_BUCKETS,
  parameter int FORMANT_BUCKETS = tqle_pkg::DEF_FORMANT_BUCKETS,
  parameter int ACTIONS         = tqle_pkg::DEF_ACTIONS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tqle_pkg::tqle_cmd_t                 cmd,
  output tqle_pkg::tqle_status_t              st,
  input  logic [tqle_pkg::RATE_W-1:0]         epsilon,
  input  logic [tqle_pkg::RATE_W-1:0]         learn_rate,
  input  logic [tqle_pkg::RATE_W-1:0]         discount,
  input  logic                                in_op,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_pitch_bucket,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_formant_bucket,
  input  logic [tqle_pkg::ACT_W-1:0]          in_taken_action,
  input  logic signed [tqle_pkg::Q_W-1:0]     in_reward,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_next_pitch_bucket,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_next_formant_bucket,
  input  logic [tqle_pkg::DRAW_W-1:0]         in_explore_draw,
  input  logic [tqle_pkg::ACT_W-1:0]          in_explore_action,
  output logic                                out_valid,
  output logic [tqle_pkg::ACT_W-1:0]          out_chosen_action,
  output logic                                out_explored,
  output logic signed [tqle_pkg::Q_W-1:0]     out_q_value,
  output logic [tqle_pkg::CNT_W-1:0]          out_visit_count
);

  localparam int DEPTH  = PITCH_BUCKETS * FORMANT_BUCKETS * ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AW     = $clog2(ACTIONS);

  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  function automatic logic [4:0] clamp_val(input logic [2:0] v, input int count);
    logic [4:0] v5;
    v5 = {2'b00, v};
    return (v5 >= 5'(count)) ? 5'(count - 1) : v5;
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(input logic [2:0] p, input logic [2:0] f);
    logic [4:0] pi;
    logic [4:0] fi;
    pi = clamp_val(p, PITCH_BUCKETS);
    fi = clamp_val(f, FORMANT_BUCKETS);
    return ADDR_W'((int'(pi) * FORMANT_BUCKETS + int'(fi)) * ACTIONS);
  endfunction

  // Remainder by the action count; the value is below eight, so a few
  // conditional subtractions cover every count.
  function automatic logic [AW-1:0] act_mod(input logic [2:0] v);
    logic [4:0] v5;
    v5 = {2'b00, v};
    for (int k = 0; k < 7; k++) begin
      if (v5 >= 5'(ACTIONS)) begin
        v5 = v5 - 5'(ACTIONS);
      end
    end
    return AW'(v5);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [35:0] y;
    y = x;
    if (x > SAT_MAX) begin
      y = SAT_MAX;
    end else if (x < SAT_MIN) begin
      y = SAT_MIN;
    end
    return y[31:0];
  endfunction

  // Tables.
  logic signed [31:0] value_mem [DEPTH];
  logic [31:0]        visit_mem [DEPTH];

  logic [ADDR_W-1:0]  clr_addr_r;
  logic               rd_v_r;
  logic               out_valid_r;
  logic [AW-1:0]      scan_i_r;
  logic [AW-1:0]      rd_idx_r;

  logic               upd_r;
  logic               explore_r;
  logic [AW-1:0]      expl_act_r;
  logic [AW-1:0]      act_r;
  logic [ADDR_W-1:0]  scan_row_r;
  logic [ADDR_W-1:0]  idx_r;
  logic signed [31:0] reward_r;

  logic signed [31:0] q_rd_r;
  logic [31:0]        c_rd_r;
  logic signed [31:0] best_q_r;
  logic [AW-1:0]      best_a_r;
  logic signed [49:0] prod_g_r;
  logic signed [31:0] target_r;
  logic signed [31:0] cur_r;
  logic [31:0]        cnt_r;
  logic signed [50:0] prod_a_r;
  logic signed [31:0] nq_r;
  logic [31:0]        ncnt_r;

  localparam int RATE_W_LOC = tqle_pkg::RATE_W;

  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic               we;
  logic signed [31:0] wq;
  logic [31:0]        wc;
  logic [RATE_W_LOC-1:0] alpha;
  logic [RATE_W_LOC-1:0] gamma;
  logic signed [34:0] tsum;
  logic signed [32:0] diff;
  logic signed [35:0] nsum;
  logic [AW-1:0]      act_sel;
  logic [7:0]         act_ext;

  assign alpha = (learn_rate > tqle_pkg::ONE_Q16) ? tqle_pkg::ONE_Q16 : learn_rate;
  assign gamma = (discount > tqle_pkg::ONE_Q16) ? tqle_pkg::ONE_Q16 : discount;

  assign raddr = cmd.scan_rd ? (scan_row_r + ADDR_W'(scan_i_r)) : idx_r;
  assign we    = cmd.clear | (cmd.emit & upd_r);
  assign waddr = cmd.clear ? clr_addr_r : idx_r;
  assign wq    = cmd.clear ? 32'sd0 : nq_r;
  assign wc    = cmd.clear ? 32'd0 : ncnt_r;

  always_ff @(posedge clk) begin
    if (we) begin
      value_mem[waddr] <= wq;
      visit_mem[waddr] <= wc;
    end
    q_rd_r <= value_mem[raddr];
    c_rd_r <= visit_mem[raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      scan_i_r    <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      rd_v_r      <= cmd.scan_rd;
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        scan_i_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_i_r <= scan_i_r + 1'b1;
      end
    end
  end

  assign tsum = 35'(reward_r) + 35'($signed(prod_g_r[49:16]));
  assign diff = 33'(target_r) - 33'(cur_r);
  assign nsum = 36'(cur_r) + 36'($signed(prod_a_r[50:16]));

  // Action of the result: the taken action for an update, the random one for
  // an exploring pick, else the best of the row.
  assign act_sel = upd_r ? act_r : (explore_r ? expl_act_r : best_a_r);
  assign act_ext = 8'(act_sel);

  // Item registers and the arithmetic steps.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upd_r      <= in_op;
      explore_r  <= st.start_explore;
      expl_act_r <= act_mod(in_explore_action);
      act_r      <= AW'(clamp_val(in_taken_action, ACTIONS));
      idx_r      <= row_base(in_pitch_bucket, in_formant_bucket)
                    + ADDR_W'(clamp_val(in_taken_action, ACTIONS));
      scan_row_r <= in_op ? row_base(in_next_pitch_bucket, in_next_formant_bucket)
                          : row_base(in_pitch_bucket, in_formant_bucket);
      reward_r   <= in_reward;
    end
    if (cmd.scan_rd) begin
      rd_idx_r <= scan_i_r;
    end
    // Strict compare keeps the lowest action on ties.
    if (rd_v_r && ((rd_idx_r == '0) || (q_rd_r > best_q_r))) begin
      best_q_r <= q_rd_r;
      best_a_r <= rd_idx_r;
    end
    if (cmd.mul_g) begin
      prod_g_r <= $signed({1'b0, gamma}) * best_q_r;
    end
    if (cmd.target) begin
      target_r <= sat32(36'(tsum));
      cur_r    <= q_rd_r;
      cnt_r    <= c_rd_r;
    end
    if (cmd.mul_a) begin
      prod_a_r <= $signed({1'b0, alpha}) * diff;
    end
    if (cmd.newq) begin
      nq_r   <= sat32(nsum);
      ncnt_r <= (&cnt_r) ? cnt_r : cnt_r + 32'd1;
    end
    if (cmd.emit) begin
      if (upd_r) begin
        out_explored      <= 1'b0;
        out_q_value       <= nq_r;
        out_visit_count   <= ncnt_r;
      end else if (explore_r) begin
        out_explored      <= 1'b1;
        out_q_value       <= 32'sd0;
        out_visit_count   <= 32'd0;
      end else begin
        out_explored      <= 1'b0;
        out_q_value       <= best_q_r;
        out_visit_count   <= 32'd0;
      end
      out_chosen_action <= act_ext[tqle_pkg::ACT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign st.clr_last      = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign st.start_explore = !in_op && ({1'b0, in_explore_draw} < epsilon);
  assign st.scan_last     = (scan_i_r == AW'(ACTIONS - 1));
  assign st.upd           = upd_r;

endmodule

/* sv/tqle_ctrl.sv */
module tqle_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  tqle_pkg::tqle_status_t st,
  output tqle_pkg::tqle_cmd_t    cmd
);

  tqle_pkg::tqle_state_t state_r;
  tqle_pkg::tqle_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tqle_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tqle_pkg::ST_CLEAR: begin
        if (st.clr_last) begin
          state_nxt = tqle_pkg::ST_IDLE;
        end
      end
      tqle_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = st.start_explore ? tqle_pkg::ST_EMIT : tqle_pkg::ST_SCAN;
        end
      end
      tqle_pkg::ST_SCAN: begin
        if (st.scan_last) begin
          state_nxt = tqle_pkg::ST_SCAN_END;
        end
      end
      tqle_pkg::ST_SCAN_END: begin
        state_nxt = st.upd ? tqle_pkg::ST_MUL_G : tqle_pkg::ST_EMIT;
      end
      tqle_pkg::ST_MUL_G:  state_nxt = tqle_pkg::ST_TARGET;
      tqle_pkg::ST_TARGET: state_nxt = tqle_pkg::ST_MUL_A;
      tqle_pkg::ST_MUL_A:  state_nxt = tqle_pkg::ST_NEWQ;
      tqle_pkg::ST_NEWQ:   state_nxt = tqle_pkg::ST_EMIT;
      tqle_pkg::ST_EMIT:   state_nxt = tqle_pkg::ST_IDLE;
      default:             state_nxt = tqle_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      tqle_pkg::ST_CLEAR: cmd.clear = 1'b1;
      tqle_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tqle_pkg::ST_SCAN:     cmd.scan_rd = 1'b1;
      tqle_pkg::ST_SCAN_END: cmd = '0;
      tqle_pkg::ST_MUL_G:    cmd.mul_g = 1'b1;
      tqle_pkg::ST_TARGET:   cmd.target = 1'b1;
      tqle_pkg::ST_MUL_A:    cmd.mul_a = 1'b1;
      tqle_pkg::ST_NEWQ:     cmd.newq = 1'b1;
      tqle_pkg::ST_EMIT:     cmd.emit = 1'b1;
      default:               cmd = '0;
    endcase
  end

  // A table scan always runs its full row before any arithmetic step.
  a_mulg_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqle_pkg::ST_MUL_G) |-> $past(st.scan_last) || $past(state_r == tqle_pkg::ST_SCAN_END))
    else $error("multiply step entered without a completed scan");

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqle_pkg::ST_IDLE && start) |=> busy)
    else $error("accepted item did not start work");

  // The clearing pass only ends into idle.
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqle_pkg::ST_CLEAR && st.clr_last) |=> (state_r == tqle_pkg::ST_IDLE))
    else $error("clearing pass did not finish into idle");

endmodule

/* bench/tqle_checker.sv */
`timescale 1ns / 100ps

package tqle_bench_pkg;

  localparam logic OP_PICK   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

endpackage

module tqle_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tqle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tqle_pkg::RATE_W-1:0]         cfg_wdata,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                in_op,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_pitch_bucket,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_formant_bucket,
  input  logic [tqle_pkg::ACT_W-1:0]          in_taken_action,
  input  logic signed [tqle_pkg::Q_W-1:0]     in_reward,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_next_pitch_bucket,
  input  logic [tqle_pkg::BUCKET_W-1:0]       in_next_formant_bucket,
  input  logic [tqle_pkg::DRAW_W-1:0]         in_explore_draw,
  input  logic [tqle_pkg::ACT_W-1:0]          in_explore_action,
  input  logic                                out_valid,
  input  logic [tqle_pkg::ACT_W-1:0]          out_chosen_action,
  input  logic                                out_explored,
  input  logic signed [tqle_pkg::Q_W-1:0]     out_q_value,
  input  logic [tqle_pkg::CNT_W-1:0]          out_visit_count,
  output int                                  fail_count,
  output int                                  outstanding
);

  import tqle_pkg::*;
  import tqle_bench_pkg::*;

  localparam int NUM_PITCH   = DEF_PITCH_BUCKETS;
  localparam int NUM_FORMANT = DEF_FORMANT_BUCKETS;
  localparam int NUM_ACTIONS = DEF_ACTIONS;
  localparam int DEPTH       = NUM_PITCH * NUM_FORMANT * NUM_ACTIONS;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             explored;
    logic [Q_W-1:0]   q_value;
    logic [CNT_W-1:0] visits;
  } decision_t;

  logic signed [Q_W-1:0] q_table [DEPTH];
  logic [CNT_W-1:0]      visit_table [DEPTH];
  logic [RATE_W-1:0]     epsilon_r;
  logic [RATE_W-1:0]     alpha_r;
  logic [RATE_W-1:0]     gamma_r;
  decision_t             awaited_decisions [$];
  int                    beats_seen = 0;

  function automatic int clamp_bucket(input logic [BUCKET_W-1:0] b, input int count);
    return (int'(b) >= count) ? count - 1 : int'(b);
  endfunction

  function automatic int row_base(input logic [BUCKET_W-1:0] p,
                                  input logic [BUCKET_W-1:0] f);
    return (clamp_bucket(p, NUM_PITCH) * NUM_FORMANT + clamp_bucket(f, NUM_FORMANT))
           * NUM_ACTIONS;
  endfunction

  function automatic logic signed [Q_W-1:0] saturate_q(input longint x);
    if (x > longint'(32'sh7FFF_FFFF))
      return 32'sh7FFF_FFFF;
    if (x < -longint'(64'h8000_0000))
      return 32'sh8000_0000;
    return x[Q_W-1:0];
  endfunction

  // Greedy scan of one row; a later action wins only when strictly larger.
  task automatic best_in_row(input int base, output int best,
                             output logic signed [Q_W-1:0] best_q);
    int a;
    best   = 0;
    best_q = q_table[base];
    for (a = 1; a < NUM_ACTIONS; a++) begin
      if (q_table[base + a] > best_q) begin
        best_q = q_table[base + a];
        best   = a;
      end
    end
  endtask

  task automatic predict_decision();
    decision_t             d;
    int                    base;
    int                    act;
    int                    best;
    int                    idx;
    logic signed [Q_W-1:0] best_q;
    logic signed [Q_W-1:0] cur;
    logic signed [Q_W-1:0] nq;
    longint                alpha;
    longint                gamma;
    longint                target;
    longint                diff;
    longint                delta;
    d    = '0;
    base = row_base(in_pitch_bucket, in_formant_bucket);
    if (in_op == OP_PICK) begin
      if ({1'b0, in_explore_draw} < epsilon_r) begin
        d.action   = ACT_W'(int'(in_explore_action) % NUM_ACTIONS);
        d.explored = 1'b1;
      end else begin
        best_in_row(base, best, best_q);
        d.action  = ACT_W'(best);
        d.q_value = best_q;
      end
    end else begin
      act   = (int'(in_taken_action) >= NUM_ACTIONS) ? NUM_ACTIONS - 1
                                                     : int'(in_taken_action);
      idx   = base + act;
      alpha = (alpha_r > ONE_Q16) ? ONE_Q16 : alpha_r;
      gamma = (gamma_r > ONE_Q16) ? ONE_Q16 : gamma_r;
      best_in_row(row_base(in_next_pitch_bucket, in_next_formant_bucket), best, best_q);
      // Arithmetic shifts of the exact products give floor truncation.
      target = longint'(in_reward) + ((gamma * longint'(best_q)) >>> 16);
      target = longint'(saturate_q(target));
      cur    = q_table[idx];
      diff   = target - longint'(cur);
      delta  = (alpha * diff) >>> 16;
      nq     = saturate_q(longint'(cur) + delta);
      q_table[idx] = nq;
      if (visit_table[idx] != '1)
        visit_table[idx] = visit_table[idx] + 1'b1;
      d.action  = ACT_W'(act);
      d.q_value = nq;
      d.visits  = visit_table[idx];
    end
    awaited_decisions.push_back(d);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: beat %0d %s: got 0x%08h, expected 0x%08h",
             $time, beats_seen, what, got, want);
    fail_count++;
  endtask

  task automatic check_beat();
    decision_t d;
    if (awaited_decisions.size() == 0) begin
      report_mismatch("arrived with nothing awaited", out_q_value, 32'h0);
    end else begin
      d = awaited_decisions.pop_front();
      if (out_chosen_action !== d.action)
        report_mismatch("chosen_action", 32'(out_chosen_action), 32'(d.action));
      if (out_explored !== d.explored)
        report_mismatch("explored", 32'(out_explored), 32'(d.explored));
      if (out_q_value !== d.q_value)
        report_mismatch("q_value", out_q_value, d.q_value);
      if (out_visit_count !== d.visits)
        report_mismatch("visit_count", out_visit_count, d.visits);
    end
    beats_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        q_table[i]     = '0;
        visit_table[i] = '0;
      end
      epsilon_r = EPSILON_RESET;
      alpha_r   = LEARN_RATE_RESET;
      gamma_r   = DISCOUNT_RESET;
      awaited_decisions.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_EPSILON:    epsilon_r = cfg_wdata;
          REG_LEARN_RATE: alpha_r   = cfg_wdata;
          REG_DISCOUNT:   gamma_r   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid === 1'b1)
        check_beat();
      if (start === 1'b1 && busy === 1'b0)
        predict_decision();
      outstanding <= awaited_decisions.size();
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  import tqle_pkg::*;
  import tqle_bench_pkg::*;

  // A run of 960 random beats split over this many configuration phases.
  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 160;
  // Cycles left after the last result before registers change or the run
  // ends, so that the block can wind down.
  localparam int SETTLE_CYCLES    = 16;
  // The longest quiet stretch in a correct run is the clearing pass after
  // reset, or the longest sender gap plus one update.
  localparam int WATCHDOG_LIMIT   = 2000;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [RATE_W-1:0]      cfg_wdata = '0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_op = OP_PICK;
  logic [BUCKET_W-1:0]    in_pitch_bucket = '0;
  logic [BUCKET_W-1:0]    in_formant_bucket = '0;
  logic [ACT_W-1:0]       in_taken_action = '0;
  logic signed [Q_W-1:0]  in_reward = '0;
  logic [BUCKET_W-1:0]    in_next_pitch_bucket = '0;
  logic [BUCKET_W-1:0]    in_next_formant_bucket = '0;
  logic [DRAW_W-1:0]      in_explore_draw = '0;
  logic [ACT_W-1:0]       in_explore_action = '0;
  logic                   out_valid;
  logic [ACT_W-1:0]       out_chosen_action;
  logic                   out_explored;
  logic signed [Q_W-1:0]  out_q_value;
  logic [CNT_W-1:0]       out_visit_count;
  int                     fail_count;
  int                     outstanding;
  int                     quiet_cycles = 0;
  // When set, the sender issues beats back to back with no idle cycles.
  logic                   no_idle_stretch = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tabular_q_learning_engine u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .start                  (start),
    .busy                   (busy),
    .in_op                  (in_op),
    .in_pitch_bucket        (in_pitch_bucket),
    .in_formant_bucket      (in_formant_bucket),
    .in_taken_action        (in_taken_action),
    .in_reward              (in_reward),
    .in_next_pitch_bucket   (in_next_pitch_bucket),
    .in_next_formant_bucket (in_next_formant_bucket),
    .in_explore_draw        (in_explore_draw),
    .in_explore_action      (in_explore_action),
    .out_valid              (out_valid),
    .out_chosen_action      (out_chosen_action),
    .out_explored           (out_explored),
    .out_q_value            (out_q_value),
    .out_visit_count        (out_visit_count)
  );

  tqle_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .start                  (start),
    .busy                   (busy),
    .in_op                  (in_op),
    .in_pitch_bucket        (in_pitch_bucket),
    .in_formant_bucket      (in_formant_bucket),
    .in_taken_action        (in_taken_action),
    .in_reward              (in_reward),
    .in_next_pitch_bucket   (in_next_pitch_bucket),
    .in_next_formant_bucket (in_next_formant_bucket),
    .in_explore_draw        (in_explore_draw),
    .in_explore_action      (in_explore_action),
    .out_valid              (out_valid),
    .out_chosen_action      (out_chosen_action),
    .out_explored           (out_explored),
    .out_q_value            (out_q_value),
    .out_visit_count        (out_visit_count),
    .fail_count             (fail_count),
    .outstanding            (outstanding)
  );

  // The watchdog restarts on any accepted beat, result beat or register
  // write. Reset also holds it, which covers the start of the run.
  always @(posedge clk) begin
    if (!rst_n || cfg_we === 1'b1 || out_valid === 1'b1 ||
        (start === 1'b1 && busy === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command beat and hold it until the block takes it. Start is
  // left high on return, so a following beat with no gap keeps it high
  // without a second assignment in the same time step.
  task automatic send_item(input logic op, input logic [BUCKET_W-1:0] pb,
                           input logic [BUCKET_W-1:0] fb, input logic [ACT_W-1:0] ta,
                           input logic [Q_W-1:0] reward, input logic [BUCKET_W-1:0] npb,
                           input logic [BUCKET_W-1:0] nfb, input logic [DRAW_W-1:0] draw,
                           input logic [ACT_W-1:0] ea);
    start                  <= 1'b1;
    in_op                  <= op;
    in_pitch_bucket        <= pb;
    in_formant_bucket      <= fb;
    in_taken_action        <= ta;
    in_reward              <= reward;
    in_next_pitch_bucket   <= npb;
    in_next_formant_bucket <= nfb;
    in_explore_draw        <= draw;
    in_explore_action      <= ea;
    @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
  endtask

  // Mostly short gaps, now and then a long one. Because start may rise while
  // the block is still busy, the gaps land on every phase of its work.
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_idle_stretch || r < 55)
      n = 0;
    else if (r < 88)
      n = $urandom_range(1, 3);
    else if (r < 97)
      n = $urandom_range(4, 14);
    else
      n = $urandom_range(20, 80);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Called right after a beat has been taken. Waits until every result has
  // come back and the block has gone idle, then writes all three registers.
  task automatic write_rates(input logic [RATE_W-1:0] eps, input logic [RATE_W-1:0] alpha,
                             input logic [RATE_W-1:0] gamma);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EPSILON;
    cfg_wdata <= eps;
    @(posedge clk);
    cfg_index <= REG_LEARN_RATE;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_index <= REG_DISCOUNT;
    cfg_wdata <= gamma;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Rates lean toward the corners: zero, exactly one, and the largest code
  // the register holds, which the block must treat as one.
  function automatic logic [RATE_W-1:0] random_rate(input logic [RATE_W-1:0] span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    if (r == 1)
      return ONE_Q16;
    if (r == 2)
      return RATE_MAX;
    return RATE_W'($urandom_range(0, int'(span)));
  endfunction

  // Most updates and picks land on a few hot states so that rows build up
  // real values, ties and negative entries; the rest roam the whole table.
  task automatic send_random_item();
    logic               op;
    logic [BUCKET_W-1:0] pb;
    logic [BUCKET_W-1:0] fb;
    logic [BUCKET_W-1:0] npb;
    logic [BUCKET_W-1:0] nfb;
    logic [Q_W-1:0]     reward;
    int                 r;
    op  = ($urandom_range(0, 99) < 55) ? OP_UPDATE : OP_PICK;
    pb  = ($urandom_range(0, 9) < 7) ? BUCKET_W'($urandom_range(0, 1))
                                     : BUCKET_W'($urandom_range(0, 7));
    fb  = ($urandom_range(0, 9) < 7) ? BUCKET_W'($urandom_range(0, 1))
                                     : BUCKET_W'($urandom_range(0, 7));
    npb = ($urandom_range(0, 9) < 7) ? BUCKET_W'($urandom_range(0, 1))
                                     : BUCKET_W'($urandom_range(0, 7));
    nfb = ($urandom_range(0, 9) < 7) ? BUCKET_W'($urandom_range(0, 1))
                                     : BUCKET_W'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    if (r < 5)
      reward = Q_W'($urandom_range(0, 32'h80000)) - 32'h40000;
    else if (r < 8)
      reward = $urandom;
    else if (r == 8)
      reward = 32'h7FFF_FFFF;
    else
      reward = 32'h8000_0000;
    send_item(op, pb, fb, ACT_W'($urandom_range(0, 7)), reward, npb, nfb,
              DRAW_W'($urandom_range(0, 65535)), ACT_W'($urandom_range(0, 7)));
  endtask

  initial begin
    int phase;
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset rates. Every row starts at zero, so the
    // first greedy pick ties across all actions and must return action 0.
    send_item(OP_PICK, 3'd0, 3'd0, 3'd0, 32'h0, 3'd0, 3'd0, 16'hFFFF, 3'd0);
    // Exploring picks: an explore action past the last one wraps around.
    send_item(OP_PICK, 3'd0, 3'd0, 3'd0, 32'h0, 3'd0, 3'd0, 16'h0000, 3'd7);
    send_item(OP_PICK, 3'd1, 3'd2, 3'd0, 32'h0, 3'd0, 3'd0, 16'd6553, 3'd4);
    // A draw equal to epsilon does not explore.
    send_item(OP_PICK, 3'd1, 3'd2, 3'd0, 32'h0, 3'd0, 3'd0, 16'd6554, 3'd5);
    // Updates at the reward extremes; a taken action past the last clamps.
    send_item(OP_UPDATE, 3'd7, 3'd7, 3'd7, 32'h7FFF_FFFF, 3'd7, 3'd7, 16'h0, 3'd0);
    send_item(OP_UPDATE, 3'd7, 3'd7, 3'd5, 32'h8000_0000, 3'd0, 3'd0, 16'h0, 3'd0);
    send_item(OP_UPDATE, 3'd7, 3'd7, 3'd2, 32'h0001_0000, 3'd7, 3'd7, 16'h0, 3'd0);
    send_item(OP_PICK, 3'd7, 3'd7, 3'd0, 32'h0, 3'd0, 3'd0, 16'hFFFF, 3'd0);
    // A row with one negative entry: the greedy pick must skip it.
    send_item(OP_UPDATE, 3'd3, 3'd5, 3'd0, 32'hFFFF_0000, 3'd3, 3'd5, 16'h0, 3'd0);
    send_item(OP_PICK, 3'd3, 3'd5, 3'd0, 32'h0, 3'd0, 3'd0, 16'hFFFF, 3'd0);

    // Never explore, alpha of one, and a discount code above one. Pushing the
    // same entry up with its own row as next state drives it into saturation.
    write_rates('0, ONE_Q16, RATE_MAX);
    send_item(OP_UPDATE, 3'd6, 3'd6, 3'd4, 32'h7FFF_FFFF, 3'd6, 3'd6, 16'h0, 3'd0);
    send_item(OP_UPDATE, 3'd6, 3'd6, 3'd4, 32'h7FFF_FFFF, 3'd6, 3'd6, 16'h0, 3'd0);
    send_item(OP_UPDATE, 3'd6, 3'd6, 3'd4, 32'h7FFF_FFFF, 3'd6, 3'd6, 16'h0, 3'd0);
    send_item(OP_UPDATE, 3'd6, 3'd6, 3'd4, 32'h8000_0000, 3'd0, 3'd1, 16'h0, 3'd0);
    send_item(OP_UPDATE, 3'd6, 3'd6, 3'd4, 32'h8000_0000, 3'd6, 3'd6, 16'h0, 3'd0);
    send_item(OP_PICK, 3'd6, 3'd6, 3'd0, 32'h0, 3'd0, 3'd0, 16'h0000, 3'd3);

    // Always explore with the largest code; a learning rate of zero leaves
    // the entry alone while its visit count still climbs.
    write_rates(RATE_MAX, '0, '0);
    send_item(OP_PICK, 3'd6, 3'd6, 3'd0, 32'h0, 3'd0, 3'd0, 16'hFFFF, 3'd6);
    send_item(OP_UPDATE, 3'd6, 3'd6, 3'd4, 32'h1234_5678, 3'd6, 3'd6, 16'h0, 3'd0);

    // Epsilon of exactly one still explores on the largest draw; rates above
    // one act as one.
    write_rates(ONE_Q16, RATE_MAX, ONE_Q16);
    send_item(OP_PICK, 3'd2, 3'd4, 3'd0, 32'h0, 3'd0, 3'd0, 16'hFFFF, 3'd1);
    send_item(OP_UPDATE, 3'd2, 3'd4, 3'd1, 32'hFFF8_0000, 3'd7, 3'd7, 16'h0, 3'd0);
    send_item(OP_UPDATE, 3'd2, 3'd4, 3'd3, 32'h0003_8000, 3'd2, 3'd4, 16'h0, 3'd0);

    // Random phases, each under fresh rates. Epsilon mostly stays below one
    // half so that greedy picks see the values the updates have built up.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_rates(random_rate(17'd32768), random_rate(ONE_Q16), random_rate(ONE_Q16));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0)
          no_idle_stretch = ($urandom_range(0, 3) == 0);
        send_random_item();
        if (n != ITEMS_PER_PHASE - 1)
          sender_gap();
      end
    end

    // Drain: the last beat has been taken, so wait for its result and let
    // the block wind down before the verdict.
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
